FILE: hw/rtl/sps_pkg.sv
// shared types and constants for the substring position search unit
// no dependencies
package sps_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int TEXT_MAX_DEF    = 4096;

  localparam int MODE_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 13;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PAT  = 2'd0,
    MODE_TEXT = 2'd1,
    MODE_END  = 2'd2,
    MODE_CLR  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_PAT_OVF = 2'd1,
    ST_TXT_OVF = 2'd2
  } status_t;

  typedef struct packed {
    logic              pat_wr;
    logic              pat_clr;
    logic              txt_push;
    logic              txt_end;
    logic [BYTE_W-1:0] data;
  } sps_ctl_t;

endpackage

FILE: hw/rtl/sps_in_if.sv
// request channel carrying mode and data byte
// depends on sps_pkg
interface sps_in_if;
  logic                       valid;
  logic                       ready;
  logic [sps_pkg::MODE_W-1:0] mode;
  logic [sps_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

FILE: hw/rtl/sps_out_if.sv
// result channel carrying position and status
// depends on sps_pkg
interface sps_out_if;
  logic                         valid;
  logic                         ready;
  logic [sps_pkg::POS_W-1:0]    position;
  logic [sps_pkg::STATUS_W-1:0] status;

  modport source (output valid, output position, output status, input ready);
  modport sink   (input valid, input position, input status, output ready);
endinterface

FILE: hw/rtl/sps_pattern.sv
// pattern byte store with fill count and overflow flag
// depends on sps_pkg
module sps_pattern #(
  parameter int PATTERN_MAX = sps_pkg::PATTERN_MAX_DEF,
  parameter int CNT_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  sps_pkg::sps_ctl_t                          ctl,
  output logic [PATTERN_MAX-1:0][sps_pkg::BYTE_W-1:0] pattern,
  output logic [CNT_W-1:0]                           pat_count,
  output logic                                       pat_ovf
);
  import sps_pkg::*;

  logic [PATTERN_MAX-1:0][BYTE_W-1:0] store_r;
  logic [CNT_W-1:0]                   count_r;
  logic                               ovf_r;
  logic                               full;

  assign full = (count_r == CNT_W'(PATTERN_MAX));

  // entries are written only below the fill count, so no reset here
  always_ff @(posedge clk) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (ctl.pat_wr && !full && (count_r == CNT_W'(i))) begin
        store_r[i] <= ctl.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (ctl.pat_clr) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (ctl.pat_wr) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  assign pattern   = store_r;
  assign pat_count = count_r;
  assign pat_ovf   = ovf_r;

endmodule

FILE: hw/rtl/sps_text.sv
// text window shift line, text counter and parallel pattern compare
// depends on sps_pkg
module sps_text #(
  parameter int PATTERN_MAX = sps_pkg::PATTERN_MAX_DEF,
  parameter int TEXT_MAX    = sps_pkg::TEXT_MAX_DEF,
  parameter int CNT_W       = $clog2(PATTERN_MAX + 1),
  parameter int TC_W        = $clog2(TEXT_MAX + 1)
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  sps_pkg::sps_ctl_t                          ctl,
  input  logic [PATTERN_MAX-1:0][sps_pkg::BYTE_W-1:0] pattern,
  input  logic [CNT_W-1:0]                           pat_count,
  output logic [TC_W-1:0]                            match_pos,
  output logic                                       txt_ovf
);
  import sps_pkg::*;

  localparam int CW = (TC_W > CNT_W) ? TC_W : CNT_W;

  logic [PATTERN_MAX-1:0][BYTE_W-1:0] win_r;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] win_nxt;
  logic [TC_W-1:0]                    tcount_r;
  logic [TC_W-1:0]                    tcount_nxt;
  logic [TC_W-1:0]                    match_r;
  logic                               ovf_r;
  logic                               full;
  logic [PATTERN_MAX-1:0]             hit_len;
  logic                               hit;
  logic [CW-1:0]                      tc_ext;
  logic [CW-1:0]                      pc_ext;
  logic [CW-1:0]                      start_ext;

  assign full       = (tcount_r == TC_W'(TEXT_MAX));
  assign tcount_nxt = tcount_r + 1'b1;

  always_comb begin
    win_nxt[0] = ctl.data;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // one compare row per candidate pattern length
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      hit_len[j] = 1'b1;
      for (int i = 0; i <= j; i++) begin
        if (pattern[i] != win_nxt[j-i]) begin
          hit_len[j] = 1'b0;
        end
      end
    end
  end

  assign tc_ext    = CW'(tcount_nxt);
  assign pc_ext    = CW'(pat_count);
  assign start_ext = tc_ext - pc_ext + 1'b1;

  always_comb begin
    hit = 1'b0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (pat_count == CNT_W'(j + 1)) begin
        hit = hit_len[j];
      end
    end
    if (tc_ext < pc_ext) begin
      hit = 1'b0;
    end
  end

  // window contents past the text count never reach the compare
  always_ff @(posedge clk) begin
    if (ctl.txt_push && !full) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcount_r <= '0;
      match_r  <= '0;
      ovf_r    <= 1'b0;
    end else if (ctl.txt_end) begin
      tcount_r <= '0;
      match_r  <= '0;
      ovf_r    <= 1'b0;
    end else if (ctl.txt_push) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        tcount_r <= tcount_nxt;
        if ((match_r == '0) && hit) begin
          match_r <= start_ext[TC_W-1:0];
        end
      end
    end
  end

  assign match_pos = match_r;
  assign txt_ovf   = ovf_r;

endmodule

FILE: hw/rtl/substring_position_search_unit.sv
// substring position search unit: pattern store, text window, result register
// an end request is held in the input register, then its result is written to the result register
// throughput: one request per cycle, but an end request stalls while the result register is still held
// reset: clears pattern count, text count, match and overflow flags at once
// depends on sps_pkg, sps_in_if, sps_out_if, sps_pattern, sps_text
module substring_position_search_unit #(
  parameter int PATTERN_MAX = sps_pkg::PATTERN_MAX_DEF,
  parameter int TEXT_MAX    = sps_pkg::TEXT_MAX_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sps_in_if.sink    in_ch,
  sps_out_if.source out_ch
);
  import sps_pkg::*;

  localparam int CNT_W = $clog2(PATTERN_MAX + 1);
  localparam int TC_W  = $clog2(TEXT_MAX + 1);

  logic                               in_v_r;
  mode_t                              in_mode_r;
  logic [BYTE_W-1:0]                  in_byte_r;
  logic                               go;
  logic                               accept;
  sps_ctl_t                           ctl;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] pattern;
  logic [CNT_W-1:0]                   pat_count;
  logic                               pat_ovf;
  logic [TC_W-1:0]                    match_pos;
  logic                               txt_ovf;
  logic                               out_v_r;
  logic [POS_W-1:0]                   out_pos_r;
  status_t                            out_st_r;
  logic [POS_W-1:0]                   pos_nxt;
  status_t                            st_nxt;

  // an end request waits only while the result register is still held
  assign go     = in_v_r && ((in_mode_r != MODE_END) || !out_v_r || out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !in_v_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (accept) begin
      in_v_r <= 1'b1;
    end else if (go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_mode_r <= mode_t'(in_ch.mode);
      in_byte_r <= in_ch.data_byte;
    end
  end

  always_comb begin
    ctl          = '0;
    ctl.data     = in_byte_r;
    if (go) begin
      unique case (in_mode_r)
        MODE_PAT:  ctl.pat_wr   = 1'b1;
        MODE_TEXT: ctl.txt_push = 1'b1;
        MODE_END:  ctl.txt_end  = 1'b1;
        MODE_CLR:  ctl.pat_clr  = 1'b1;
        default:   ctl          = '0;
      endcase
    end
  end

  sps_pattern #(
    .PATTERN_MAX (PATTERN_MAX),
    .CNT_W       (CNT_W)
  ) u_pattern (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .pattern   (pattern),
    .pat_count (pat_count),
    .pat_ovf   (pat_ovf)
  );

  sps_text #(
    .PATTERN_MAX (PATTERN_MAX),
    .TEXT_MAX    (TEXT_MAX),
    .CNT_W       (CNT_W),
    .TC_W        (TC_W)
  ) u_text (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .pattern   (pattern),
    .pat_count (pat_count),
    .match_pos (match_pos),
    .txt_ovf   (txt_ovf)
  );

  // empty pattern always reports the first position
  always_comb begin
    pos_nxt = (pat_count == '0) ? POS_W'(1) : POS_W'(match_pos);
    if (pat_ovf) begin
      st_nxt = ST_PAT_OVF;
    end else if (txt_ovf) begin
      st_nxt = ST_TXT_OVF;
    end else begin
      st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ctl.txt_end) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.txt_end) begin
      out_pos_r <= pos_nxt;
      out_st_r  <= st_nxt;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.status   = out_st_r;

endmodule
